>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the box filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define BFM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define BFM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bfm_pkg.sv
// Shared constants, types and helpers of the 3x3 box filter.
package bfm_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int PIXEL_BITS_DEF = 8;

   // window sums need room for nine pixels
   localparam int SUM_EXTRA_BITS = 4;

   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 16;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_WIDTH_BITS-1:0]  RST_FRAME_WIDTH  = 11'd640;
   localparam logic [CFG_HEIGHT_BITS-1:0] RST_FRAME_HEIGHT = 16'd480;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // result queue depth, power of two (pointers wrap)
   localparam int FIFO_DEPTH = 8;

   typedef enum logic [2:0] {
      DIV_1,
      DIV_2,
      DIV_3,
      DIV_4,
      DIV_6,
      DIV_9
   } div_code_type;

   typedef struct packed {
      logic         valid;
      logic         last;
      div_code_type code;
   } lane_ctl_type;

   // divisor from rows and columns of the in-frame neighbourhood (1..3 each)
   function automatic div_code_type div_code(input logic [1:0] rows, input logic [1:0] cols);
      div_code_type code;
      unique case ({rows, cols})
         4'b0101: code = DIV_1;
         4'b0110: code = DIV_2;
         4'b0111: code = DIV_3;
         4'b1001: code = DIV_2;
         4'b1010: code = DIV_4;
         4'b1011: code = DIV_6;
         4'b1101: code = DIV_3;
         4'b1110: code = DIV_6;
         4'b1111: code = DIV_9;
         default: code = DIV_1;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/bfm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bfm_div.sv
// Constant divider lane: reciprocal multiply stage, then shift to the mean.
module bfm_div #(
   parameter int PIXEL_BITS = bfm_pkg::PIXEL_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  bfm_pkg::lane_ctl_type                        in_ctl,
   input  logic [PIXEL_BITS+bfm_pkg::SUM_EXTRA_BITS-1:0] in_sum,
   output bfm_pkg::lane_ctl_type                        out_ctl,
   output logic [PIXEL_BITS-1:0]                        out_mean
);

   localparam int SUM_BITS  = PIXEL_BITS + bfm_pkg::SUM_EXTRA_BITS;
   localparam int MULT_BITS = SUM_BITS + 1;
   localparam int PROD_BITS = SUM_BITS + MULT_BITS;
   // floor(x*M >> K) is exact for x < 2**SUM_BITS with these shifts
   localparam int K3 = SUM_BITS + 1;
   localparam int K9 = SUM_BITS + 3;
   localparam logic [MULT_BITS-1:0] M3 = MULT_BITS'(((64'd1 << K3) + 64'd2) / 64'd3);
   localparam logic [MULT_BITS-1:0] M9 = MULT_BITS'(((64'd1 << K9) + 64'd8) / 64'd9);

   logic [SUM_BITS-1:0]   operand;
   logic [MULT_BITS-1:0]  mult;
   logic [PROD_BITS-1:0]  prod_in, prod_ff;
   logic [PROD_BITS-1:0]  quot;
   bfm_pkg::lane_ctl_type ctl_ff;

   always_comb begin
      case (in_ctl.code)
         bfm_pkg::DIV_2: begin
            operand = in_sum >> 1;
            mult    = MULT_BITS'(1);
         end
         bfm_pkg::DIV_3: begin
            operand = in_sum;
            mult    = M3;
         end
         bfm_pkg::DIV_4: begin
            operand = in_sum >> 2;
            mult    = MULT_BITS'(1);
         end
         bfm_pkg::DIV_6: begin
            operand = in_sum >> 1;
            mult    = M3;
         end
         bfm_pkg::DIV_9: begin
            operand = in_sum;
            mult    = M9;
         end
         default: begin
            operand = in_sum;
            mult    = MULT_BITS'(1);
         end
      endcase
   end

   assign prod_in = PROD_BITS'(operand) * PROD_BITS'(mult);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= in_ctl.valid;
      end
      ctl_ff.last <= in_ctl.last;
      ctl_ff.code <= in_ctl.code;
      prod_ff     <= prod_in;
   end

   always_comb begin
      case (ctl_ff.code) inside
         bfm_pkg::DIV_3, bfm_pkg::DIV_6: quot = prod_ff >> K3;
         bfm_pkg::DIV_9:                 quot = prod_ff >> K9;
         default:                        quot = prod_ff;
      endcase
   end

   assign out_ctl  = ctl_ff;
   assign out_mean = quot[PIXEL_BITS-1:0];

endmodule

>>> rtl/bfm_fifo.sv
// Result queue: up to two pushes and one pop per cycle.
module bfm_fifo #(
   parameter int WIDTH = 9
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push_a,
   input  logic [WIDTH-1:0]                         push_data_a,
   input  logic                                     push_b,
   input  logic [WIDTH-1:0]                         push_data_b,
   input  logic                                     pop,
   output logic                                     out_valid,
   output logic [WIDTH-1:0]                         out_data,
   output logic [$clog2(bfm_pkg::FIFO_DEPTH+1)-1:0] level
);

   localparam int PTR_BITS = $clog2(bfm_pkg::FIFO_DEPTH);
   localparam int LVL_BITS = $clog2(bfm_pkg::FIFO_DEPTH + 1);

   logic [WIDTH-1:0]    data_ff [bfm_pkg::FIFO_DEPTH];
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [LVL_BITS-1:0] level_ff, level_in;
   logic [1:0]          n_push;
   logic [WIDTH-1:0]    first_data;

   always_comb begin
      n_push     = 2'(push_a) + 2'(push_b);
      first_data = push_a ? push_data_a : push_data_b;
      tail_in    = tail_ff + PTR_BITS'(n_push);
      head_in    = head_ff + PTR_BITS'(pop);
      level_in   = level_ff + LVL_BITS'(n_push) - LVL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a || push_b) begin
         data_ff[tail_ff] <= first_data;
      end
      if (push_a && push_b) begin
         data_ff[tail_ff + PTR_BITS'(1)] <= push_data_b;
      end
   end

   assign out_valid = level_ff != '0;
   assign out_data  = data_ff[head_ff];
   assign level     = level_ff;

endmodule

>>> rtl/box_filter_3x3_mean.sv
// Top level of the edge-aware 3x3 box filter.
//
// Pixels come in on the req channel in raster order, one request per pixel
// (req_type = pixel) for a frame of frame_width x frame_height set over the
// csr port; a csr write restarts the frame. Each result on the rsp channel is
// the truncated mean of the in-frame 3x3 neighbourhood of one pixel.
// The result of pixel (r,c) is made by the request of pixel (r+1,c+1); the
// last column of a row also makes the right-edge result of the row above.
// After the last pixel, width further requests (drain ticks or pixels) flush
// the bottom row; rsp_frame_end marks the bottom-right result.
// Throughput: one request per cycle while req_stall is low. A result can be
// taken once its request has passed the window/sum register, the divider
// multiply register and the result queue. A row end yields two results while
// the rsp side takes at most one per cycle; an 8-entry result queue absorbs
// that, and req_stall rises only when the queue and pipeline could overflow.
// When the receiver stalls, the queue fills and req_stall follows.
// Synchronous reset empties pipeline and queue, clears the counters and sets
// width 640, height 480; the line stores need no clearing.
module box_filter_3x3_mean #(
   parameter int MAX_WIDTH  = bfm_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = bfm_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [PIXEL_BITS-1:0]              req_pixel_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [PIXEL_BITS-1:0]              rsp_smooth_out,
   output logic                               rsp_frame_end,
   input  logic                               csr_write_en,
   input  logic [bfm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bfm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int SUM_BITS = PIXEL_BITS + bfm_pkg::SUM_EXTRA_BITS;
   localparam int LVL_BITS = $clog2(bfm_pkg::FIFO_DEPTH + 1);
   localparam int CNT_BITS = LVL_BITS + 1;
   localparam int HB       = bfm_pkg::CFG_HEIGHT_BITS;

   logic [bfm_pkg::CFG_WIDTH_BITS-1:0] frame_width_ff, frame_width_in;
   logic [HB-1:0]                      frame_height_ff, frame_height_in;
   logic [COL_BITS-1:0]                col_ff, col_in;
   logic [HB-1:0]                      row_ff, row_in;

   logic [PIXEL_BITS-1:0] prev1_ff [3];
   logic [PIXEL_BITS-1:0] prev2_ff [3];

   logic                  byp_ff, byp_in;
   logic [PIXEL_BITS-1:0] byp_upper_ff, byp_middle_ff;

   logic [HB-1:0]         width_ext, width_eff, height_eff;
   logic [COL_BITS-1:0]   last_col;
   logic                  draining, accept, pix_step, step, at_last;
   logic                  top_ok, bot_ok, has_rows, c_ge1, c_ge2;
   logic [PIXEL_BITS-1:0] upper_rd, middle_rd, cur_top, cur_mid, cur_bot;
   logic [SUM_BITS-1:0]   s0, s1, s2, sum_a_in, sum_b_in, sum_a_ff, sum_b_ff;
   logic [1:0]            n_rows;

   bfm_pkg::lane_ctl_type lane_a_in, lane_b_in, lane_a_ff, lane_b_ff;
   bfm_pkg::lane_ctl_type div_a_ctl, div_b_ctl;
   logic [PIXEL_BITS-1:0] div_a_mean, div_b_mean;

   logic [LVL_BITS-1:0]   fifo_level;
   logic [PIXEL_BITS:0]   fifo_out;
   logic [2:0]            inflight;
   logic [CNT_BITS-1:0]   need;

   // ---- frame geometry ----
   always_comb begin
      width_ext = HB'(frame_width_ff);
      width_eff = width_ext;
      if (width_ext == '0) begin
         width_eff = HB'(1);
      end else if (width_ext > HB'(MAX_WIDTH)) begin
         width_eff = HB'(MAX_WIDTH);
      end
      height_eff = (frame_height_ff == '0) ? HB'(1) : frame_height_ff;
   end

   assign last_col = COL_BITS'(width_eff - HB'(1));

   // ---- step control ----
   assign draining = row_ff >= height_eff;
   assign accept   = req_valid && !req_stall;
   assign pix_step = accept && !draining && (req_type == bfm_pkg::REQ_PIXEL);
   assign step     = pix_step || (accept && draining);
   assign at_last  = col_ff == last_col;
   assign top_ok   = draining ? (height_eff >= HB'(2)) : (row_ff >= HB'(2));
   assign bot_ok   = !draining;
   assign has_rows = draining || (row_ff != '0);
   assign c_ge1    = col_ff != '0;
   assign c_ge2    = col_ff > COL_BITS'(1);

   // ---- line stores, read one column ahead ----
   bfm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper_line (
      .clock   (clock),
      .wr_en   (pix_step),
      .wr_addr (col_ff),
      .wr_data (cur_mid),
      .rd_addr (col_in),
      .rd_data (upper_rd)
   );

   bfm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle_line (
      .clock   (clock),
      .wr_en   (pix_step),
      .wr_addr (col_ff),
      .wr_data (req_pixel_in),
      .rd_addr (col_in),
      .rd_data (middle_rd)
   );

   // one-pixel-wide frames read the column being written
   assign byp_in  = pix_step && (col_in == col_ff);
   assign cur_top = byp_ff ? byp_upper_ff : upper_rd;
   assign cur_mid = byp_ff ? byp_middle_ff : middle_rd;
   assign cur_bot = draining ? '0 : req_pixel_in;

   // ---- window sums ----
   always_comb begin
      s0 = (top_ok ? SUM_BITS'(cur_top) : '0) + SUM_BITS'(cur_mid)
         + (bot_ok ? SUM_BITS'(cur_bot) : '0);
      s1 = (top_ok ? SUM_BITS'(prev1_ff[0]) : '0) + SUM_BITS'(prev1_ff[1])
         + (bot_ok ? SUM_BITS'(prev1_ff[2]) : '0);
      s2 = (top_ok ? SUM_BITS'(prev2_ff[0]) : '0) + SUM_BITS'(prev2_ff[1])
         + (bot_ok ? SUM_BITS'(prev2_ff[2]) : '0);
      n_rows = 2'd1 + 2'(top_ok) + 2'(bot_ok);

      // lane a: pixel to the left; lane b: right-edge pixel at row end
      sum_a_in        = (c_ge2 ? s2 : '0) + s1 + s0;
      lane_a_in.valid = step && has_rows && c_ge1;
      lane_a_in.last  = 1'b0;
      lane_a_in.code  = bfm_pkg::div_code(n_rows, c_ge2 ? 2'd3 : 2'd2);

      sum_b_in        = (c_ge1 ? s1 : '0) + s0;
      lane_b_in.valid = step && has_rows && at_last;
      lane_b_in.last  = draining;
      lane_b_in.code  = bfm_pkg::div_code(n_rows, c_ge1 ? 2'd2 : 2'd1);
   end

   // ---- counters and configuration ----
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            bfm_pkg::CSR_FRAME_WIDTH:
               frame_width_in = csr_wdata[bfm_pkg::CFG_WIDTH_BITS-1:0];
            bfm_pkg::CSR_FRAME_HEIGHT:
               frame_height_in = csr_wdata[HB-1:0];
         endcase
         col_in = '0;
         row_in = '0;
      end else if (step) begin
         if (at_last) begin
            col_in = '0;
            row_in = draining ? '0 : row_ff + HB'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bfm_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= bfm_pkg::RST_FRAME_HEIGHT;
         col_ff          <= '0;
         row_ff          <= '0;
         byp_ff          <= 1'b0;
         lane_a_ff.valid <= 1'b0;
         lane_b_ff.valid <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         byp_ff          <= byp_in;
         lane_a_ff.valid <= lane_a_in.valid;
         lane_b_ff.valid <= lane_b_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      byp_upper_ff   <= cur_mid;
      byp_middle_ff  <= req_pixel_in;
      lane_a_ff.last <= lane_a_in.last;
      lane_a_ff.code <= lane_a_in.code;
      lane_b_ff.last <= lane_b_in.last;
      lane_b_ff.code <= lane_b_in.code;
      sum_a_ff       <= sum_a_in;
      sum_b_ff       <= sum_b_in;
      if (step) begin
         prev2_ff    <= prev1_ff;
         prev1_ff[0] <= cur_top;
         prev1_ff[1] <= cur_mid;
         prev1_ff[2] <= cur_bot;
      end
   end

   // ---- dividers ----
   bfm_div #(.PIXEL_BITS(PIXEL_BITS)) u_div_a (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (lane_a_ff),
      .in_sum   (sum_a_ff),
      .out_ctl  (div_a_ctl),
      .out_mean (div_a_mean)
   );

   bfm_div #(.PIXEL_BITS(PIXEL_BITS)) u_div_b (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (lane_b_ff),
      .in_sum   (sum_b_ff),
      .out_ctl  (div_b_ctl),
      .out_mean (div_b_mean)
   );

   // ---- result queue ----
   bfm_fifo #(.WIDTH(PIXEL_BITS + 1)) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_a      (div_a_ctl.valid),
      .push_data_a ({div_a_ctl.last, div_a_mean}),
      .push_b      (div_b_ctl.valid),
      .push_data_b ({div_b_ctl.last, div_b_mean}),
      .pop         (rsp_valid && !rsp_stall),
      .out_valid   (rsp_valid),
      .out_data    (fifo_out),
      .level       (fifo_level)
   );

   assign rsp_smooth_out = fifo_out[PIXEL_BITS-1:0];
   assign rsp_frame_end  = fifo_out[PIXEL_BITS];

   // room for everything in flight plus two results of a new request
   assign inflight  = 3'(lane_a_ff.valid) + 3'(lane_b_ff.valid)
                    + 3'(div_a_ctl.valid) + 3'(div_b_ctl.valid);
   assign need      = CNT_BITS'(fifo_level) + CNT_BITS'(inflight) + CNT_BITS'(2);
   assign req_stall = need > CNT_BITS'(bfm_pkg::FIFO_DEPTH);

endmodule

>>> rtl/bfm_checker.sv
// Port-level assertions for the box filter, bound to the top level.
`include "assert_macros.svh"

module bfm_checker #(
   parameter int PIXEL_BITS = bfm_pkg::PIXEL_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [PIXEL_BITS-1:0] rsp_smooth_out,
   input logic                  rsp_frame_end
);

   `BFM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "reset left results or stall")
   `BFM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_smooth_out) && $stable(rsp_frame_end), "stalled result changed")
   `BFM_ASSERT(a_no_orphan, clock, reset, !rsp_valid && !$past(req_valid && !req_stall, 2) |=> !rsp_valid, "result without a request")
   `BFM_ASSERT(a_empty_ready, clock, reset, !rsp_valid |-> !req_stall, "stall with empty result queue")

endmodule

bind box_filter_3x3_mean bfm_checker #(.PIXEL_BITS(PIXEL_BITS)) u_bfm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_smooth_out (rsp_smooth_out),
   .rsp_frame_end  (rsp_frame_end)
);
